>>> rtl/olrf_pkg.sv
// Shared constants, phase codes and the queue entry type of the list renumbering filter.
`timescale 1ns / 1ps
`default_nettype none
package olrf_pkg;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [3:0] NUM_MAX  = 4'd9;
   localparam logic [3:0] NUM_ONE  = 4'd1;

   localparam int OLRF_QUEUE_DEPTH = 4;

   typedef enum logic [3:0] {
      PH_START = 4'b0001,
      PH_DIGIT = 4'b0010,
      PH_DOT   = 4'b0100,
      PH_MID   = 4'b1000
   } phase_type;

   // One queue entry: up to three output characters of one input item.
   typedef struct packed {
      logic [7:0] char0;
      logic [7:0] char1;
      logic [7:0] char2;
      logic [1:0] count;
      logic       fin;
   } cmd_type;

endpackage
`default_nettype wire

>>> rtl/ordered_list_renumber_filter_unit.sv
// Ordered-list renumbering filter: one character in per cycle while the command queue has room,
// renumbered list prefixes out. An accepted item's results pass through the command queue and the
// serializer's current-command register. An item's results are emitted one character at a time,
// so the output serializer sets the sustained rate at one result character per cycle while rsp_ready is high.
// The command queue (QUEUE_DEPTH entries) absorbs bursts of multi-character results.
// Reset (synchronous, active high) returns to line start, list number 1, queue empty.
`timescale 1ns / 1ps
`default_nettype none
module ordered_list_renumber_filter_unit
   import olrf_pkg::*;
#(
   parameter int QUEUE_DEPTH = OLRF_QUEUE_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_in_final,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_run_last,
   output logic            rsp_text_end
);

   logic    push;
   cmd_type push_cmd;
   logic    q_full;
   logic    q_pop;
   logic    q_not_empty;
   cmd_type q_head;

   olrf_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_in_byte  (req_in_byte),
      .req_in_final (req_in_final),
      .q_full       (q_full),
      .push         (push),
      .push_cmd     (push_cmd)
   );

   olrf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_cmd  (q_head)
   );

   olrf_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_not_empty  (q_not_empty),
      .q_head       (q_head),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_run_last (rsp_run_last),
      .rsp_text_end (rsp_text_end)
   );

endmodule
`default_nettype wire

>>> rtl/olrf_front.sv
// Front end: tracks the list prefix of each line and turns items into output commands.
`timescale 1ns / 1ps
`default_nettype none
module olrf_front
   import olrf_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_in_final,
   input  wire logic       q_full,
   output logic            push,
   output cmd_type         push_cmd
);

   phase_type  phase_ff, phase_in;
   logic [7:0] held_ff, held_in;
   logic [3:0] number_ff, number_in;
   logic       run_ff, run_in;
   logic       accept;
   logic       is_digit;
   logic [3:0] num;
   phase_type  after;
   cmd_type    cmd;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign is_digit  = (req_in_byte >= CH_ZERO) && (req_in_byte <= CH_NINE);
   assign after     = (req_in_byte == CH_NL) ? PH_START : PH_MID;

   always_comb begin
      num = run_ff ? number_ff : NUM_ONE;
      if (num > NUM_MAX) begin
         num = NUM_MAX;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      held_in   = held_ff;
      number_in = number_ff;
      run_in    = run_ff;
      cmd       = '{char0: req_in_byte, char1: req_in_byte, char2: req_in_byte,
                    count: 2'd1, fin: req_in_final};
      unique case (phase_ff)
         PH_START: begin
            if (is_digit && !req_in_final) begin
               held_in   = req_in_byte;
               phase_in  = PH_DIGIT;
               cmd.count = 2'd0;
            end else begin
               run_in   = 1'b0;
               phase_in = after;
            end
         end
         PH_DIGIT: begin
            if (req_in_byte == CH_DOT && !req_in_final) begin
               phase_in  = PH_DOT;
               cmd.count = 2'd0;
            end else begin
               run_in    = 1'b0;
               cmd.char0 = held_ff;
               cmd.char1 = req_in_byte;
               cmd.count = 2'd2;
               phase_in  = after;
            end
         end
         PH_DOT: begin
            cmd.count = 2'd3;
            if (req_in_byte == CH_SPACE) begin
               cmd.char0 = CH_ZERO + {4'd0, num};
               cmd.char1 = CH_DOT;
               cmd.char2 = CH_SPACE;
               number_in = (num >= NUM_MAX) ? NUM_MAX : num + 4'd1;
               run_in    = 1'b1;
               phase_in  = PH_MID;
            end else begin
               run_in    = 1'b0;
               cmd.char0 = held_ff;
               cmd.char1 = CH_DOT;
               cmd.char2 = req_in_byte;
               phase_in  = after;
            end
         end
         PH_MID: begin
            phase_in = after;
         end
         default: begin
            phase_in = PH_START;
         end
      endcase
      // end of text: start the next text from reset state
      if (req_in_final) begin
         phase_in  = PH_START;
         number_in = NUM_ONE;
         run_in    = 1'b0;
      end
   end

   assign push     = accept && (cmd.count != 2'd0);
   assign push_cmd = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_START;
         number_ff <= NUM_ONE;
         run_ff    <= 1'b0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         number_ff <= number_in;
         run_ff    <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_final_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && req_in_final |=> phase_ff == PH_START && !run_ff)
      else $error("phase not back at line start after end of text");
   a_number_range: assert property (@(posedge clock) disable iff (reset)
      number_ff >= NUM_ONE && number_ff <= NUM_MAX)
      else $error("list number out of range");
`endif

endmodule
`default_nettype wire

>>> rtl/olrf_queue.sv
// Command queue between the front end and the output serializer.
`timescale 1ns / 1ps
`default_nettype none
module olrf_queue
   import olrf_pkg::*;
#(
   parameter int DEPTH = OLRF_QUEUE_DEPTH
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   output logic         full,
   input  wire logic    pop,
   output logic         not_empty,
   output cmd_type      head_cmd
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cmd_type        mem_ff [DEPTH];
   logic [PW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]  count_ff;
   logic           do_pop;

   assign full      = count_ff == CW'(DEPTH);
   assign not_empty = count_ff != '0;
   assign head_cmd  = mem_ff[rd_ptr_ff];
   assign do_pop    = pop && not_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end
         if (push && !do_pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (do_pop && !push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into full queue");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

>>> rtl/olrf_back.sv
// Back end: emits the characters of each queued command one per cycle while rsp_ready is high.
`timescale 1ns / 1ps
`default_nettype none
module olrf_back
   import olrf_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    q_not_empty,
   input  wire cmd_type q_head,
   output logic         q_pop,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output logic [7:0]   rsp_out_byte,
   output logic         rsp_run_last,
   output logic         rsp_text_end
);

   cmd_type    cur_ff;
   logic       cur_valid_ff;
   logic [1:0] idx_ff;
   logic       last;
   logic       done;

   assign last  = idx_ff == (cur_ff.count - 2'd1);
   assign done  = !cur_valid_ff || (rsp_ready && last);
   assign q_pop = done && q_not_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else if (done) begin
         cur_valid_ff <= q_not_empty;
         idx_ff       <= 2'd0;
      end else if (rsp_ready) begin
         idx_ff <= idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_head;
      end
   end

   always_comb begin
      case (idx_ff)
         2'd0:    rsp_out_byte = cur_ff.char0;
         2'd1:    rsp_out_byte = cur_ff.char1;
         default: rsp_out_byte = cur_ff.char2;
      endcase
   end

   assign rsp_valid    = cur_valid_ff;
   assign rsp_run_last = last;
   assign rsp_text_end = last && cur_ff.fin;

`ifndef NO_ASSERTIONS
   a_index_in_command: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> cur_ff.count != 2'd0 && idx_ff < cur_ff.count)
      else $error("character index beyond command length");
`endif

endmodule
`default_nettype wire
